[design/ospc_pkg.sv]
// ----------------------------------------------------------------------------
// ospc_pkg
// Shared types, constants and constant tables of the ozone ppb conversion
// ----------------------------------------------------------------------------
package ospc_pkg;

    // field widths
    localparam int ADC_FIELD_W = 14;
    localparam int ADC_WIDTH   = 14;
    localparam int TEMP_W      = 11;
    localparam int HUM_W       = 10;
    localparam int PPB_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int RES_W       = 34;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;

    // datapath widths
    localparam int FM_W    = ADC_WIDTH + 1;
    localparam int SCALE_W = FM_W + 22;
    localparam int NUM_W   = SCALE_W + 16;
    localparam int DEN_W   = ADC_WIDTH + RES_W;
    localparam int DIV_W   = DEN_W + 23;
    localparam int Q_W     = 24;
    localparam int FRAC_W  = 20;
    localparam int ACC_W   = 31;
    localparam int GP_W    = ACC_W + 20;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADC_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

    // register index
    localparam logic REG_BASELINE = 1'b0;
    localparam logic [RES_W-1:0] BASELINE_RESET = 34'd1000000;

    // arithmetic constants
    localparam logic [21:0] SCALE_4M   = 22'd4000000;
    localparam logic [29:0] RECIP_10K  = 30'd879609303;
    localparam int          RECIP_SH   = 43;
    localparam logic [22:0] EXP_Q20    = 23'd2448215;
    localparam logic [19:0] GAIN_Q16   = 20'd621170;
    localparam logic [15:0] CORR_ONE   = 16'd16384;

    // per-stage tag that rides along with each transaction
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                zero_res;
    } t_tag;

    // integer square root on 64 bits, elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // factor 2^(2^-(idx+1)) in Q1.30, built by repeated square roots
    function automatic logic [ACC_W-1:0] exp_root(input int idx);
        logic [63:0] root;
        root = 64'd1 << 31;
        for (int i = 0; i <= idx; i++) begin
            root = isqrt64(root << 30);
        end
        return root[ACC_W-1:0];
    endfunction

endpackage

[design/ospc_div_cell.sv]
// ----------------------------------------------------------------------------
// ospc_div_cell
// One restoring division step: yields one quotient bit per cell
// ----------------------------------------------------------------------------
module ospc_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  ospc_pkg::t_tag               i_tag,
    input  logic [ospc_pkg::NUM_W-1:0]   i_rem,
    input  logic [ospc_pkg::DIV_W-1:0]   i_div,
    input  logic [ospc_pkg::Q_W-1:0]     i_quo,
    output ospc_pkg::t_tag               o_tag,
    output logic [ospc_pkg::NUM_W-1:0]   o_rem,
    output logic [ospc_pkg::DIV_W-1:0]   o_div,
    output logic [ospc_pkg::Q_W-1:0]     o_quo
);

    ospc_pkg::t_tag                r_tag;
    logic [ospc_pkg::NUM_W-1:0]    r_rem, n_rem;
    logic [ospc_pkg::DIV_W-1:0]    r_div;
    logic [ospc_pkg::Q_W-1:0]      r_quo, n_quo;
    logic                          fits;

    // compare and subtract the shifted divisor
    always_comb begin
        fits = {{(ospc_pkg::DIV_W-ospc_pkg::NUM_W){1'b0}}, i_rem} >= i_div;
        n_rem = fits ? (i_rem - i_div[ospc_pkg::NUM_W-1:0]) : i_rem;
        n_quo = {i_quo[ospc_pkg::Q_W-2:0], fits};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_div <= i_div >> 1;
            r_quo <= n_quo;
        end
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

[design/ospc_log_cell.sv]
// ----------------------------------------------------------------------------
// ospc_log_cell
// One squaring step of the log2 fraction: yields one fraction bit per cell
// ----------------------------------------------------------------------------
module ospc_log_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ospc_pkg::t_tag                i_tag,
    input  logic [31:0]                   i_x,
    input  logic [ospc_pkg::FRAC_W-1:0]   i_frac,
    input  logic [4:0]                    i_msb,
    output ospc_pkg::t_tag                o_tag,
    output logic [31:0]                   o_x,
    output logic [ospc_pkg::FRAC_W-1:0]   o_frac,
    output logic [4:0]                    o_msb
);

    ospc_pkg::t_tag                 r_tag;
    logic [31:0]                    r_x, n_x;
    logic [ospc_pkg::FRAC_W-1:0]    r_frac, n_frac;
    logic [4:0]                     r_msb;
    logic [63:0]                    sq;

    // square in Q1.31 and renormalize
    always_comb begin
        sq = i_x * i_x;
        n_frac = {i_frac[ospc_pkg::FRAC_W-2:0], sq[63]};
        n_x = sq[63] ? sq[63:32] : sq[62:31];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_frac <= n_frac;
            r_msb  <= i_msb;
        end
    end

    assign o_tag  = r_tag;
    assign o_x    = r_x;
    assign o_frac = r_frac;
    assign o_msb  = r_msb;

endmodule

[design/ospc_exp_cell.sv]
// ----------------------------------------------------------------------------
// ospc_exp_cell
// One factor of the fractional power of two: multiplies in one root factor
// ----------------------------------------------------------------------------
module ospc_exp_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  ospc_pkg::t_tag                i_tag,
    input  logic [ospc_pkg::ACC_W-1:0]    i_root,
    input  logic                          i_bit,
    input  logic [ospc_pkg::ACC_W-1:0]    i_acc,
    input  logic [ospc_pkg::FRAC_W-1:0]   i_fpart,
    input  logic [7:0]                    i_ip,
    output ospc_pkg::t_tag                o_tag,
    output logic [ospc_pkg::ACC_W-1:0]    o_acc,
    output logic [ospc_pkg::FRAC_W-1:0]   o_fpart,
    output logic [7:0]                    o_ip
);

    ospc_pkg::t_tag                 r_tag;
    logic [ospc_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [ospc_pkg::FRAC_W-1:0]    r_fpart;
    logic [7:0]                     r_ip;
    logic [2*ospc_pkg::ACC_W-1:0]   prod;

    // conditional Q1.30 product
    always_comb begin
        prod  = i_acc * i_root;
        n_acc = i_bit ? prod[ospc_pkg::ACC_W+29:30] : i_acc;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc   <= n_acc;
            r_fpart <= i_fpart;
            r_ip    <= i_ip;
        end
    end

    assign o_tag   = r_tag;
    assign o_acc   = r_acc;
    assign o_fpart = r_fpart;
    assign o_ip    = r_ip;

endmodule

[design/ozone_sensor_ppb_conversion.sv]
// ----------------------------------------------------------------------------
// ozone_sensor_ppb_conversion
// Converts a sensor sample with temperature and humidity into ozone ppb
// ----------------------------------------------------------------------------
// throughput: one sample per cycle; the whole chain advances together and
//   holds while the output register waits on m_axis_tready
// reset: synchronous active low, clears all valid flags and sets the
//   baseline resistance to 1000000 ohm; no clearing pass
module ozone_sensor_ppb_conversion (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // adc_sample[13:0], temperature_tenths[24:14], humidity_tenths[34:25]
    input  logic [ospc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ozone_ppb[31:0], status[33:32]
    output logic [ospc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ospc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ospc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ospc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int NDIV = ospc_pkg::Q_W;
    localparam int NLOG = ospc_pkg::FRAC_W;
    localparam int NEXP = ospc_pkg::FRAC_W;

    logic en;
    logic [ospc_pkg::RES_W-1:0] r_baseline;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= ospc_pkg::BASELINE_RESET;
        end else if (psel && penable && pwrite && paddr[3] == ospc_pkg::REG_BASELINE) begin
            r_baseline <= pwdata[ospc_pkg::RES_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == ospc_pkg::REG_BASELINE)
                    ? {{(ospc_pkg::APB_DATA_W-ospc_pkg::RES_W){1'b0}}, r_baseline}
                    : '0;

    // chain advance
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: field split and divide by ten ----------------
    logic [ospc_pkg::ADC_WIDTH-1:0] in_adc;
    logic [ospc_pkg::TEMP_W-1:0]    in_temp;
    logic [ospc_pkg::HUM_W-1:0]     in_hum;
    logic [10:0]                    t_mag;
    logic [18:0]                    t_prod;
    logic [17:0]                    h_prod;
    logic [7:0]                     n1_deg;

    ospc_pkg::t_tag                 r1_tag;
    logic [ospc_pkg::ADC_WIDTH-1:0] r1_adc;
    logic signed [7:0]              r1_deg;
    logic [6:0]                     r1_hum;

    always_comb begin
        in_adc  = s_axis_tdata[ospc_pkg::ADC_WIDTH-1:0];
        in_temp = s_axis_tdata[24:14];
        in_hum  = s_axis_tdata[34:25];
        t_mag   = in_temp[10] ? (~in_temp + 11'd1) : in_temp;
        t_prod  = t_mag * 8'd205;
        h_prod  = in_hum * 8'd205;
        n1_deg  = in_temp[10] ? (~{1'b0, t_prod[17:11]} + 8'd1) : {1'b0, t_prod[17:11]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
        end else if (en) begin
            r1_tag.valid    <= s_axis_tvalid;
            r1_tag.status   <= ospc_pkg::ST_OK;
            r1_tag.zero_res <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_adc <= in_adc;
            r1_deg <= n1_deg;
            r1_hum <= h_prod[17:11];
        end
    end

    // ---------------- stage 2: correction line and products ----------------
    logic [14:0]        c_base;
    logic [7:0]         c_coef;
    logic signed [16:0] c_v;
    logic signed [16:0] c_slope;

    ospc_pkg::t_tag                  r2_tag;
    logic [29:0]                     r2_n;
    logic                            r2_one;
    logic                            r2_neg;
    logic [ospc_pkg::SCALE_W-1:0]    r2_scale;
    logic [ospc_pkg::DEN_W-1:0]      r2_den;
    logic                            r2_adc_zero;

    always_comb begin
        priority if (r1_hum > 7'd75) begin
            c_base = 15'd11507;
            c_coef = 8'd103;
        end else if (r1_hum > 7'd50) begin
            c_base = 15'd13261;
            c_coef = 8'd119;
        end else begin
            c_base = 15'd15623;
            c_coef = 8'd141;
        end
        c_slope = $signed({1'b0, c_coef}) * r1_deg;
        c_v     = $signed({2'b00, c_base}) - c_slope;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (en) begin
            r2_tag <= r1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_n        <= {1'b0, c_v[14:0], 14'd0} + 30'd5000;
            r2_neg      <= c_v[16];
            r2_one      <= (r1_hum == 7'd60) && (r1_deg == 8'sd20);
            r2_scale    <= (((ospc_pkg::FM_W)'(1) << ospc_pkg::ADC_WIDTH) - {1'b0, r1_adc})
                           * ospc_pkg::SCALE_4M;
            r2_den      <= r1_adc * ((r_baseline == '0) ? (ospc_pkg::RES_W)'(1) : r_baseline);
            r2_adc_zero <= (r1_adc == '0);
        end
    end

    // ---------------- stage 3: divide by ten thousand ----------------
    logic [59:0] c_prod;

    ospc_pkg::t_tag                  r3_tag;
    logic [15:0]                     r3_corr;
    logic [ospc_pkg::SCALE_W-1:0]    r3_scale;
    logic [ospc_pkg::DEN_W-1:0]      r3_den;

    assign c_prod = r2_n * ospc_pkg::RECIP_10K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else if (en) begin
            r3_tag.valid    <= r2_tag.valid;
            r3_tag.status   <= r2_adc_zero ? ospc_pkg::ST_ADC_ZERO : r2_tag.status;
            r3_tag.zero_res <= r2_tag.zero_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (r2_one) begin
                r3_corr <= ospc_pkg::CORR_ONE;
            end else if (r2_neg) begin
                r3_corr <= '0;
            end else begin
                r3_corr <= c_prod[ospc_pkg::RECIP_SH+15:ospc_pkg::RECIP_SH];
            end
            r3_scale <= r2_scale;
            r3_den   <= r2_den;
        end
    end

    // ---------------- stage 4: numerator ----------------
    ospc_pkg::t_tag                  r4_tag;
    logic [ospc_pkg::NUM_W-1:0]      r4_num;
    logic [ospc_pkg::DEN_W-1:0]      r4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
        end else if (en) begin
            r4_tag <= r3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_num <= r3_scale * r3_corr;
            r4_den <= r3_den;
        end
    end

    // ---------------- stage 5: ratio range check ----------------
    logic ratio_big;

    ospc_pkg::t_tag              div_tag [NDIV+1];
    logic [ospc_pkg::NUM_W-1:0]  div_rem [NDIV+1];
    logic [ospc_pkg::DIV_W-1:0]  div_div [NDIV+1];
    logic [ospc_pkg::Q_W-1:0]    div_quo [NDIV+1];

    assign ratio_big = {{(ospc_pkg::DEN_W+24-ospc_pkg::NUM_W){1'b0}}, r4_num}
                       >= {r4_den, 24'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_tag[0] <= '0;
        end else if (en) begin
            div_tag[0].valid    <= r4_tag.valid;
            div_tag[0].status   <= (r4_tag.status == ospc_pkg::ST_OK && ratio_big)
                                   ? ospc_pkg::ST_SAT : r4_tag.status;
            div_tag[0].zero_res <= r4_tag.zero_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            div_rem[0] <= r4_num;
            div_div[0] <= {r4_den, 23'd0};
            div_quo[0] <= '0;
        end
    end

    // ---------------- division cells ----------------
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        ospc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (div_tag[g]),
            .i_rem   (div_rem[g]),
            .i_div   (div_div[g]),
            .i_quo   (div_quo[g]),
            .o_tag   (div_tag[g+1]),
            .o_rem   (div_rem[g+1]),
            .o_div   (div_div[g+1]),
            .o_quo   (div_quo[g+1])
        );
    end

    // ---------------- normalize the ratio ----------------
    logic [4:0]  lz_msb;
    logic [31:0] lz_x;

    ospc_pkg::t_tag               log_tag  [NLOG+1];
    logic [31:0]                  log_x    [NLOG+1];
    logic [ospc_pkg::FRAC_W-1:0]  log_frac [NLOG+1];
    logic [4:0]                   log_msb  [NLOG+1];

    always_comb begin
        lz_msb = '0;
        for (int i = 0; i < ospc_pkg::Q_W; i++) begin
            if (div_quo[NDIV][i]) begin
                lz_msb = 5'(i);
            end
        end
        lz_x = {8'd0, div_quo[NDIV]} << (5'd31 - lz_msb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            log_tag[0] <= '0;
        end else if (en) begin
            log_tag[0].valid    <= div_tag[NDIV].valid;
            log_tag[0].status   <= div_tag[NDIV].status;
            log_tag[0].zero_res <= (div_quo[NDIV] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            log_x[0]    <= lz_x;
            log_frac[0] <= '0;
            log_msb[0]  <= lz_msb;
        end
    end

    // ---------------- log2 cells ----------------
    for (genvar g = 0; g < NLOG; g++) begin : g_log
        ospc_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (log_tag[g]),
            .i_x     (log_x[g]),
            .i_frac  (log_frac[g]),
            .i_msb   (log_msb[g]),
            .o_tag   (log_tag[g+1]),
            .o_x     (log_x[g+1]),
            .o_frac  (log_frac[g+1]),
            .o_msb   (log_msb[g+1])
        );
    end

    // ---------------- scale the log by the exponent ----------------
    logic signed [25:0] lg;
    logic signed [48:0] lg_prod;
    logic signed [28:0] lg_t;

    ospc_pkg::t_tag               exp_tag   [NEXP+1];
    logic [ospc_pkg::ACC_W-1:0]   exp_acc   [NEXP+1];
    logic [ospc_pkg::FRAC_W-1:0]  exp_fpart [NEXP+1];
    logic [7:0]                   exp_ip    [NEXP+1];

    always_comb begin
        lg      = $signed({1'b0, log_msb[NLOG], 20'd0}) - $signed(26'd16 << 20)
                  + $signed({6'd0, log_frac[NLOG]});
        lg_prod = lg * $signed({1'b0, ospc_pkg::EXP_Q20});
        lg_t    = lg_prod[48:20];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            exp_tag[0] <= '0;
        end else if (en) begin
            exp_tag[0] <= log_tag[NLOG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            exp_acc[0]   <= (ospc_pkg::ACC_W)'(1) << 30;
            exp_fpart[0] <= lg_t[19:0];
            exp_ip[0]    <= lg_t[27:20];
        end
    end

    // ---------------- power of two cells ----------------
    for (genvar g = 0; g < NEXP; g++) begin : g_exp
        ospc_exp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (exp_tag[g]),
            .i_root  (ospc_pkg::exp_root(g)),
            .i_bit   (exp_fpart[g][NEXP-1-g]),
            .i_acc   (exp_acc[g]),
            .i_fpart (exp_fpart[g]),
            .i_ip    (exp_ip[g]),
            .o_tag   (exp_tag[g+1]),
            .o_acc   (exp_acc[g+1]),
            .o_fpart (exp_fpart[g+1]),
            .o_ip    (exp_ip[g+1])
        );
    end

    // ---------------- gain and shift amount ----------------
    ospc_pkg::t_tag             rf_tag;
    logic [ospc_pkg::GP_W-1:0]  rf_gp;
    logic signed [7:0]          rf_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_tag <= '0;
        end else if (en) begin
            rf_tag <= exp_tag[NEXP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rf_gp <= exp_acc[NEXP] * ospc_pkg::GAIN_Q16;
            rf_sh <= 8'sd38 - $signed(exp_ip[NEXP]);
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic [5:0]                 sh_m1;
    logic [ospc_pkg::GP_W-1:0]  sh_val;
    logic [ospc_pkg::GP_W:0]    rnd;
    logic                       sh_far;
    logic [ospc_pkg::PPB_W-1:0]    n_ppb;
    logic [ospc_pkg::STATUS_W-1:0] n_status;

    logic                          r_out_valid;
    logic [ospc_pkg::PPB_W-1:0]    r_ppb;
    logic [ospc_pkg::STATUS_W-1:0] r_status;

    always_comb begin
        sh_m1  = 6'(rf_sh - 8'sd1);
        sh_far = (rf_sh >= 8'sd64) || (rf_sh <= 8'sd0);
        sh_val = rf_gp >> sh_m1;
        rnd    = ({1'b0, sh_val} + 1'b1) >> 1;
        n_status = rf_tag.status;
        priority if (rf_tag.status == ospc_pkg::ST_SAT) begin
            n_ppb = '1;
        end else if (rf_tag.status == ospc_pkg::ST_ADC_ZERO || rf_tag.zero_res || sh_far) begin
            n_ppb = '0;
        end else if (rnd[ospc_pkg::GP_W:ospc_pkg::PPB_W] != '0) begin
            n_ppb    = '1;
            n_status = ospc_pkg::ST_SAT;
        end else begin
            n_ppb = rnd[ospc_pkg::PPB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= rf_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ppb    <= n_ppb;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_status, r_ppb};

endmodule

[design/ospc_checker.sv]
// ----------------------------------------------------------------------------
// ospc_checker
// Port-level checks of the ozone ppb conversion, bound to the top level
// ----------------------------------------------------------------------------
module ospc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [ospc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

    // status code stays in its defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] == ospc_pkg::ST_OK
                        || m_axis_tdata[33:32] == ospc_pkg::ST_ADC_ZERO
                        || m_axis_tdata[33:32] == ospc_pkg::ST_SAT))
        else $error("undefined status code");

    // zero sample gives zero ppb
    a_zero_adc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] == ospc_pkg::ST_ADC_ZERO)
        |-> m_axis_tdata[31:0] == '0)
        else $error("zero sample with nonzero ppb");

    // saturation gives full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[33:32] == ospc_pkg::ST_SAT)
        |-> m_axis_tdata[31:0] == '1)
        else $error("saturated status without full-scale ppb");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind ozone_sensor_ppb_conversion ospc_checker u_ospc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
